### src/mdc_pkg.sv
// ----------------------------------------------------------------------------
// mdc_pkg
// Shared types and constants for the maximum divisor count range unit.
// ----------------------------------------------------------------------------
package mdc_pkg;

    localparam int NUM_W   = 31;   // width of a range bound / number
    localparam int COUNT_W = 11;   // width of a divisor count
    localparam int DIVR_W  = 16;   // trial divisor width (up to 46341)
    localparam int SQ_W    = 32;   // square of a trial divisor
    localparam int EXP_W   = 5;    // prime exponent, at most 30

    typedef struct packed {
        logic [NUM_W-1:0] range_low;
        logic [NUM_W-1:0] range_high;
    } t_in;

    typedef struct packed {
        logic [NUM_W-1:0]   best_number;
        logic [COUNT_W-1:0] best_count;
        logic               range_error;
    } t_out;

    // controller -> datapath
    typedef struct packed {
        logic load_query;
        logic set_err;
        logic init_num;
        logic div_start;
        logic div_take;
        logic next_div;
        logic num_end;
        logic next_num;
        logic load_out;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic range_bad;
        logic sq_gt_m;
        logic div_done;
        logic rem_zero;
        logic last_num;
    } t_status;

endpackage

### src/max_divisor_count_in_range_unit.sv
// ----------------------------------------------------------------------------
// max_divisor_count_in_range_unit
// Rejected range: the check state goes straight to the result state.
//   Valid range: each number runs trial divisions in turn; divisors are 2
//   then odd values up to sqrt of the cofactor, each trial a full serial
//   division, and the query walks every number of the span.
// Throughput: one query at a time; set by the 1-bit-per-cycle divider loop.
// Reset: synchronous active low, clears sequencer, output valid and divider counter/done only.
// ----------------------------------------------------------------------------
module max_divisor_count_in_range_unit #(
    parameter int MAX_SPAN = 1024
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  mdc_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output mdc_pkg::t_out o_out_data
);
    import mdc_pkg::*;

    // Controller walks numbers and trial divisors; datapath holds the
    // cofactor, divisor, its square, the running count and the best so far.
    t_cmd    w_cmd;
    t_status w_status;

    mdc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    // Output beat register lives in the datapath; it is reloaded only once
    // the previous beat has been taken.
    mdc_datapath #(
        .MAX_SPAN (MAX_SPAN)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_data  (i_in_data),
        .i_cmd      (w_cmd),
        .o_status   (w_status),
        .o_out_data (o_out_data)
    );

    // one query in flight: ready drops right after an accepted beat
    a_one_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input accepted twice in a row");

    // error beats always carry number one with count one
    a_err_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.range_error) |->
        (o_out_data.best_number == NUM_W'(1) && o_out_data.best_count == COUNT_W'(1)))
        else $error("error beat with nonunit result");

    // a result beat never carries a zero count or zero number
    a_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.best_count != '0 && o_out_data.best_number != '0))
        else $error("zero in result beat");

endmodule

### src/mdc_div.sv
// ----------------------------------------------------------------------------
// mdc_div
// Restoring divider, one quotient bit per cycle; 31-bit by 16-bit.
// ----------------------------------------------------------------------------
module mdc_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [mdc_pkg::NUM_W-1:0]   i_dividend,
    input  logic [mdc_pkg::DIVR_W-1:0]  i_divisor,
    output logic                        o_done,
    output logic [mdc_pkg::NUM_W-1:0]   o_quotient,
    output logic                        o_rem_zero
);
    import mdc_pkg::*;

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [CNT_W-1:0]  r_left;
    logic              r_done;
    logic [NUM_W-1:0]  r_quo;
    logic [DIVR_W:0]   r_rem;

    logic [DIVR_W:0]   w_trial;
    logic              w_ge;
    logic [DIVR_W:0]   w_diff;

    assign w_trial = {r_rem[DIVR_W-1:0], r_quo[NUM_W-1]};
    assign w_ge    = (w_trial >= {1'b0, i_divisor});
    assign w_diff  = w_trial - {1'b0, i_divisor};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= (r_left == CNT_W'(1));
            if (i_start) begin
                r_left <= CNT_W'(NUM_W);
            end else if (r_left != '0) begin
                r_left <= r_left - CNT_W'(1);
            end
        end
    end

    // divisor must hold steady while a division runs
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
        end else if (r_left != '0) begin
            r_quo <= {r_quo[NUM_W-2:0], w_ge};
            r_rem <= w_ge ? w_diff : w_trial;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;
    assign o_rem_zero = (r_rem == '0);

endmodule

### src/mdc_datapath.sv
// ----------------------------------------------------------------------------
// mdc_datapath
// Number walk, trial divisor stepping, divisor count and best tracking.
// ----------------------------------------------------------------------------
module mdc_datapath #(
    parameter int MAX_SPAN = 1024
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mdc_pkg::t_in      i_in_data,
    input  mdc_pkg::t_cmd     i_cmd,
    output mdc_pkg::t_status  o_status,
    output mdc_pkg::t_out     o_out_data
);
    import mdc_pkg::*;

    localparam logic [NUM_W-1:0] SPAN_M1 = NUM_W'(MAX_SPAN - 1);

    logic [NUM_W-1:0]   r_n;
    logic [NUM_W-1:0]   r_hi;
    logic [NUM_W-1:0]   r_m;
    logic [COUNT_W-1:0] r_cnt;
    logic [EXP_W-1:0]   r_e;
    logic [DIVR_W-1:0]  r_d;
    logic [SQ_W-1:0]    r_sq;
    logic [NUM_W-1:0]   r_best_n;
    logic [COUNT_W-1:0] r_best_c;
    logic               r_err;
    t_out               r_out;

    logic [EXP_W-1:0]   w_e1;
    logic [COUNT_W-1:0] w_prod;
    logic [COUNT_W-1:0] w_cnt_fin;
    logic               w_div_done;
    logic [NUM_W-1:0]   w_quo;
    logic               w_rem_zero;

    mdc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_m),
        .i_divisor  (r_d),
        .o_done     (w_div_done),
        .o_quotient (w_quo),
        .o_rem_zero (w_rem_zero)
    );

    assign w_e1      = r_e + EXP_W'(1);
    assign w_prod    = COUNT_W'(16'(r_cnt) * 16'(w_e1));
    // leftover cofactor above one is one more prime
    assign w_cnt_fin = (r_m > NUM_W'(1)) ? {r_cnt[COUNT_W-2:0], 1'b0} : r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_query) begin
            r_n      <= i_in_data.range_low;
            r_hi     <= i_in_data.range_high;
            r_best_n <= NUM_W'(1);
            r_best_c <= COUNT_W'(1);
            r_err    <= 1'b0;
        end
        if (i_cmd.set_err) begin
            r_err <= 1'b1;
        end
        if (i_cmd.init_num) begin
            r_m   <= r_n;
            r_cnt <= COUNT_W'(1);
            r_e   <= '0;
            r_d   <= DIVR_W'(2);
            r_sq  <= SQ_W'(4);
        end
        if (i_cmd.div_take) begin
            r_m <= w_quo;
            r_e <= w_e1;
        end
        if (i_cmd.next_div) begin
            r_cnt <= w_prod;
            r_e   <= '0;
            if (r_d == DIVR_W'(2)) begin
                r_d  <= DIVR_W'(3);
                r_sq <= SQ_W'(9);
            end else begin
                // (d+2)^2 = d^2 + 4d + 4
                r_d  <= r_d + DIVR_W'(2);
                r_sq <= r_sq + {{(SQ_W-DIVR_W-2){1'b0}}, r_d, 2'b00} + SQ_W'(4);
            end
        end
        if (i_cmd.num_end && (w_cnt_fin > r_best_c)) begin
            r_best_c <= w_cnt_fin;
            r_best_n <= r_n;
        end
        if (i_cmd.next_num) begin
            r_n <= r_n + NUM_W'(1);
        end
        if (i_cmd.load_out) begin
            r_out.best_number <= r_best_n;
            r_out.best_count  <= r_best_c;
            r_out.range_error <= r_err;
        end
    end

    assign o_status.range_bad = (r_n == '0) || (r_hi < r_n) || ((r_hi - r_n) > SPAN_M1);
    assign o_status.sq_gt_m   = (r_sq > {1'b0, r_m});
    assign o_status.div_done  = w_div_done;
    assign o_status.rem_zero  = w_rem_zero;
    assign o_status.last_num  = (r_n == r_hi);

    assign o_out_data = r_out;

endmodule

### src/mdc_ctrl.sv
// ----------------------------------------------------------------------------
// mdc_ctrl
// Sequencer for range check, number walk and trial division loop.
// ----------------------------------------------------------------------------
module mdc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  mdc_pkg::t_status  i_status,
    output mdc_pkg::t_cmd     o_cmd
);
    import mdc_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_INIT,
        S_TEST,
        S_DIV_WAIT,
        S_DIV_GO,
        S_NUM_END,
        S_RESULT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   w_out_free;

    assign w_out_free = !r_out_valid || i_out_ready;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_query = 1'b1;
                    n_state          = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_status.range_bad) begin
                    o_cmd.set_err = 1'b1;
                    n_state       = S_RESULT;
                end else begin
                    n_state = S_INIT;
                end
            end
            S_INIT: begin
                o_cmd.init_num = 1'b1;
                n_state        = S_TEST;
            end
            S_TEST: begin
                if (i_status.sq_gt_m) begin
                    n_state = S_NUM_END;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIV_WAIT;
                end
            end
            S_DIV_WAIT: begin
                if (i_status.div_done) begin
                    if (i_status.rem_zero) begin
                        o_cmd.div_take = 1'b1;
                        n_state        = S_DIV_GO;
                    end else begin
                        o_cmd.next_div = 1'b1;
                        n_state        = S_TEST;
                    end
                end
            end
            S_DIV_GO: begin
                // same divisor again until it stops dividing
                o_cmd.div_start = 1'b1;
                n_state         = S_DIV_WAIT;
            end
            S_NUM_END: begin
                o_cmd.num_end = 1'b1;
                if (i_status.last_num) begin
                    n_state = S_RESULT;
                end else begin
                    o_cmd.next_num = 1'b1;
                    n_state        = S_INIT;
                end
            end
            S_RESULT: begin
                if (w_out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule
